/* rtl/pmlb_pkg.sv */
package pmlb_pkg;

  localparam int SAMPLE_W = 16;
  localparam int MAG_W    = SAMPLE_W + 1;
  localparam int LEDS_W   = 7;
  localparam int CHUNK_W  = 13;
  localparam int SENS_W   = 16;
  localparam int CFG_W    = 16;
  localparam int CFG_IDX_W = 2;

  localparam int LED_MAX   = 64;
  localparam int CHUNK_MAX = 4096;
  localparam int IDX_W     = $clog2(LED_MAX);

  localparam int COLOUR_W = 24;
  localparam int LIT_SHIFT = 23;
  localparam int PROD1_W  = MAG_W + LEDS_W;
  localparam int PROD2_W  = PROD1_W + SENS_W;
  localparam int LIT_W    = PROD2_W - LIT_SHIFT;

  localparam int THIRD_MUL   = 683;
  localparam int THIRD_SHIFT = 11;
  localparam int THIRD_W     = LEDS_W + 1 + 10;

  localparam logic [COLOUR_W-1:0] COL_OFF    = 24'h000000;
  localparam logic [COLOUR_W-1:0] COL_GREEN  = 24'h440000;
  localparam logic [COLOUR_W-1:0] COL_YELLOW = 24'h444400;
  localparam logic [COLOUR_W-1:0] COL_RED    = 24'h004400;

  localparam logic [CFG_IDX_W-1:0] REG_LED_COUNT   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CHUNK_SIZE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SENSITIVITY = 2'd2;

  localparam logic [LEDS_W-1:0]  LED_COUNT_RST   = 7'd60;
  localparam logic [CHUNK_W-1:0] CHUNK_SIZE_RST  = 13'd1024;
  localparam logic [SENS_W-1:0]  SENSITIVITY_RST = 16'd51200;

  typedef struct packed {
    logic [MAG_W-1:0]  peak;
    logic [LEDS_W-1:0] leds;
    logic [SENS_W-1:0] sens;
  } frame_t;

endpackage

/* rtl/pmlb_ifs.sv */
interface pmlb_sample_if;
  logic                                valid;
  logic                                ready;
  logic signed [pmlb_pkg::SAMPLE_W-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface pmlb_led_if;
  logic                              valid;
  logic                              ready;
  logic [pmlb_pkg::IDX_W-1:0]        led_index;
  logic [pmlb_pkg::COLOUR_W-1:0]     colour;
  logic                              last_led;

  modport source (output valid, output led_index, output colour, output last_led,
                  input ready);
  modport sink   (input valid, input led_index, input colour, input last_led,
                  output ready);
endinterface

/* rtl/pmlb_front.sv */
module pmlb_front (
  input  logic                              clk,
  input  logic                              rst,
  pmlb_sample_if.sink                       samples,
  input  logic [pmlb_pkg::LEDS_W-1:0]       led_count,
  input  logic [pmlb_pkg::CHUNK_W-1:0]      chunk_size,
  input  logic [pmlb_pkg::SENS_W-1:0]       sensitivity,
  input  logic                              q_full,
  output logic                              push,
  output pmlb_pkg::frame_t                  push_data
);

  logic [pmlb_pkg::CHUNK_W-1:0] count;
  logic [pmlb_pkg::CHUNK_W-1:0] count_next;
  logic [pmlb_pkg::CHUNK_W-1:0] chunk_eff;
  logic [pmlb_pkg::MAG_W-1:0]   peak;
  logic [pmlb_pkg::MAG_W-1:0]   peak_next;
  logic [pmlb_pkg::MAG_W-1:0]   mag;
  logic [pmlb_pkg::LEDS_W-1:0]  leds_eff;
  logic                         accept;
  logic                         chunk_end;

  assign samples.ready = !q_full;
  assign accept        = samples.valid && samples.ready;

  assign mag = samples.sample[pmlb_pkg::SAMPLE_W-1]
             ? (pmlb_pkg::MAG_W'(0) - {samples.sample[pmlb_pkg::SAMPLE_W-1], samples.sample})
             : {1'b0, samples.sample};
  assign peak_next = (mag > peak) ? mag : peak;

  always_comb begin
    priority if (chunk_size == '0) begin
      chunk_eff = pmlb_pkg::CHUNK_W'(1);
    end else if (chunk_size > pmlb_pkg::CHUNK_W'(pmlb_pkg::CHUNK_MAX)) begin
      chunk_eff = pmlb_pkg::CHUNK_W'(pmlb_pkg::CHUNK_MAX);
    end else begin
      chunk_eff = chunk_size;
    end
  end

  assign leds_eff = (led_count > pmlb_pkg::LEDS_W'(pmlb_pkg::LED_MAX))
                  ? pmlb_pkg::LEDS_W'(pmlb_pkg::LED_MAX) : led_count;

  assign count_next = count + pmlb_pkg::CHUNK_W'(1);
  assign chunk_end  = count_next >= chunk_eff;

  assign push           = accept && chunk_end && (leds_eff != '0);
  assign push_data.peak = peak_next;
  assign push_data.leds = leds_eff;
  assign push_data.sens = sensitivity;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      peak  <= '0;
    end else if (accept) begin
      if (chunk_end) begin
        count <= '0;
        peak  <= '0;
      end else begin
        count <= count_next;
        peak  <= peak_next;
      end
    end
  end

endmodule

/* rtl/pmlb_queue.sv */
module pmlb_queue #(
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  pmlb_pkg::frame_t push_data,
  input  logic             pop,
  output pmlb_pkg::frame_t pop_data,
  output logic             full,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  pmlb_pkg::frame_t  entries [DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  fill;
  logic              do_push;
  logic              do_pop;

  assign full     = fill == CNT_W'(DEPTH);
  assign empty    = fill == '0;
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      unique case ({do_push, do_pop})
        2'b10:   fill <= fill + CNT_W'(1);
        2'b01:   fill <= fill - CNT_W'(1);
        default: fill <= fill;
      endcase
    end
  end

endmodule

/* rtl/pmlb_back.sv */
module pmlb_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             q_empty,
  input  pmlb_pkg::frame_t q_data,
  output logic             pop,
  pmlb_led_if.source       leds
);

  typedef enum logic [1:0] {
    IDLE,
    MUL1,
    MUL2,
    EMIT
  } state_t;

  state_t                          state;
  pmlb_pkg::frame_t                frame;
  logic [pmlb_pkg::PROD1_W-1:0]    prod1;
  logic [pmlb_pkg::PROD2_W-1:0]    prod2;
  logic [pmlb_pkg::LIT_W-1:0]      lit_raw;
  logic [pmlb_pkg::LEDS_W-1:0]     lit;
  logic [pmlb_pkg::THIRD_W-1:0]    third1_full;
  logic [pmlb_pkg::THIRD_W-1:0]    third2_full;
  logic [pmlb_pkg::LEDS_W-1:0]     third1;
  logic [pmlb_pkg::LEDS_W-1:0]     third2;
  logic [pmlb_pkg::LEDS_W-1:0]     idx;
  logic [pmlb_pkg::LEDS_W-1:0]     idx_next;
  logic [pmlb_pkg::COLOUR_W-1:0]   colour_next;
  logic                            load;

  assign pop = (state == IDLE) && !q_empty;

  assign third1_full = pmlb_pkg::THIRD_W'(frame.leds) * pmlb_pkg::THIRD_W'(pmlb_pkg::THIRD_MUL);
  assign third2_full = pmlb_pkg::THIRD_W'({frame.leds, 1'b0})
                     * pmlb_pkg::THIRD_W'(pmlb_pkg::THIRD_MUL);

  assign prod2   = pmlb_pkg::PROD2_W'(prod1) * pmlb_pkg::PROD2_W'(frame.sens);
  assign lit_raw = prod2[pmlb_pkg::PROD2_W-1:pmlb_pkg::LIT_SHIFT];

  assign idx_next = idx + pmlb_pkg::LEDS_W'(1);
  assign load     = (state == EMIT) && (!leds.valid || leds.ready);

  always_comb begin
    priority if (idx >= lit) begin
      colour_next = pmlb_pkg::COL_OFF;
    end else if (idx < third1) begin
      colour_next = pmlb_pkg::COL_GREEN;
    end else if (idx < third2) begin
      colour_next = pmlb_pkg::COL_YELLOW;
    end else begin
      colour_next = pmlb_pkg::COL_RED;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= IDLE;
      leds.valid <= 1'b0;
    end else begin
      if (leds.valid && leds.ready && !load) begin
        leds.valid <= 1'b0;
      end
      unique case (state)
        IDLE: begin
          if (!q_empty) begin
            frame <= q_data;
            state <= MUL1;
          end
        end
        MUL1: begin
          prod1  <= pmlb_pkg::PROD1_W'(frame.peak) * pmlb_pkg::PROD1_W'(frame.leds);
          third1 <= pmlb_pkg::LEDS_W'(third1_full >> pmlb_pkg::THIRD_SHIFT);
          third2 <= pmlb_pkg::LEDS_W'(third2_full >> pmlb_pkg::THIRD_SHIFT);
          state  <= MUL2;
        end
        MUL2: begin
          lit   <= (lit_raw > pmlb_pkg::LIT_W'(frame.leds))
                 ? frame.leds : pmlb_pkg::LEDS_W'(lit_raw);
          idx   <= '0;
          state <= EMIT;
        end
        EMIT: begin
          if (load) begin
            leds.valid     <= 1'b1;
            leds.led_index <= idx[pmlb_pkg::IDX_W-1:0];
            leds.colour    <= colour_next;
            leds.last_led  <= idx_next == frame.leds;
            idx            <= idx_next;
            if (idx_next == frame.leds) begin
              state <= IDLE;
            end
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

endmodule

/* rtl/peak_meter_led_bar.sv */
// Takes one sample per cycle; input stalls only while the frame queue is full.
// A frame of min(led_count, 64) LEDs, none if led_count is 0, follows the
// sample closing a chunk via the queue and back-end states IDLE, MUL1, MUL2
// (two multiply steps); EMIT then sends one LED per cycle while sink is ready.
// Synchronous reset clears the chunk, the queue and the output beat, and
// loads led_count 60, chunk_size 1024 and sensitivity 51200.
module peak_meter_led_bar #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [pmlb_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [pmlb_pkg::CFG_W-1:0]         cfg_data,
  pmlb_sample_if.sink                        samples,
  pmlb_led_if.source                         leds
);

  logic [pmlb_pkg::LEDS_W-1:0]  led_count;
  logic [pmlb_pkg::CHUNK_W-1:0] chunk_size;
  logic [pmlb_pkg::SENS_W-1:0]  sensitivity;

  logic             push;
  logic             pop;
  logic             q_full;
  logic             q_empty;
  pmlb_pkg::frame_t push_data;
  pmlb_pkg::frame_t pop_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      led_count   <= pmlb_pkg::LED_COUNT_RST;
      chunk_size  <= pmlb_pkg::CHUNK_SIZE_RST;
      sensitivity <= pmlb_pkg::SENSITIVITY_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        pmlb_pkg::REG_LED_COUNT:   led_count   <= cfg_data[pmlb_pkg::LEDS_W-1:0];
        pmlb_pkg::REG_CHUNK_SIZE:  chunk_size  <= cfg_data[pmlb_pkg::CHUNK_W-1:0];
        pmlb_pkg::REG_SENSITIVITY: sensitivity <= cfg_data[pmlb_pkg::SENS_W-1:0];
        default: ;
      endcase
    end
  end

  pmlb_front u_front (
    .clk         (clk),
    .rst         (rst),
    .samples     (samples),
    .led_count   (led_count),
    .chunk_size  (chunk_size),
    .sensitivity (sensitivity),
    .q_full      (q_full),
    .push        (push),
    .push_data   (push_data)
  );

  pmlb_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .full      (q_full),
    .empty     (q_empty)
  );

  pmlb_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_empty (q_empty),
    .q_data  (pop_data),
    .pop     (pop),
    .leds    (leds)
  );

endmodule
